/* rtl/dcc_pkg.sv */
package dcc_pkg;

    // default width of the colour index
    localparam int COLOR_BITS_DEF = 24;

    // low colour bits that pick a bit inside one memory row
    localparam int SEL_BITS = 6;
    localparam int ROW_BITS = 1 << SEL_BITS;

    // fixed width of the distinct_count field
    localparam int COUNT_WIDTH = 25;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic                   is_new;
        logic [COUNT_WIDTH-1:0] distinct_count;
    } result_t;

endpackage

/* rtl/distinct_color_counter_unit.sv */
// Distinct colour counter. Each input beat carries one RGB pixel; the colour index
// is {blue, green, red}, truncated to COLOR_BITS bits. Each pixel gives exactly one
// result beat: is_new is 1 when the colour had not been seen since reset, and
// distinct_count is the number of distinct colours seen, this pixel included.
// Rate: one pixel per clock, sustained while m_ready stays high. The result beat
// is registered from the read stage once the output register is free.
// A result that waits holds the next pixel in the read stage, and s_ready
// stays low until the output register frees. The presence bitmap sits in one
// memory of 2^(COLOR_BITS-6) rows of 64 bits, with one read and one write port.
// A pixel reads its row on acceptance. At the edge that moves it into the output
// register it sets the bit and writes the row back if it was clear. A one-entry
// write-forwarding register covers a read of a row issued in the same cycle as
// its write. After reset the block runs a clearing pass over all 2^(COLOR_BITS-6)
// rows (262144 at the default width), one row per cycle. During the pass s_ready
// stays low.
module distinct_color_counter_unit
    import dcc_pkg::*;
#(
    parameter int COLOR_BITS = COLOR_BITS_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,

    input  logic    s_valid,
    output logic    s_ready,
    input  pixel_t  s_pixel,

    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    localparam int ROW_IDX_BITS = COLOR_BITS - SEL_BITS;
    localparam int ROWS         = 1 << ROW_IDX_BITS;
    localparam int CNT_BITS     = COLOR_BITS + 1;
    localparam logic [CNT_BITS-1:0] MAP_ENTRIES = {1'b1, {COLOR_BITS{1'b0}}};

    // bitmap memory, one row holds 64 colour bits
    logic [ROW_BITS-1:0]     map_mem [ROWS];
    logic [ROW_BITS-1:0]     rd_data_reg;

    // clearing pass after reset
    logic                    clr_active_reg;
    logic [ROW_IDX_BITS-1:0] clr_row_reg;

    // read stage: pixel waiting for its row
    logic                    s1_valid_reg;
    logic [ROW_IDX_BITS-1:0] s1_row_reg;
    logic [SEL_BITS-1:0]     s1_sel_reg;

    // last row written, for forwarding
    logic                    wr_valid_reg;
    logic [ROW_IDX_BITS-1:0] wr_row_reg;
    logic [ROW_BITS-1:0]     wr_data_reg;

    logic [CNT_BITS-1:0]     count_reg;
    logic [CNT_BITS-1:0]     count_next;

    logic                    m_valid_reg;
    result_t                 m_result_reg;

    logic [COLOR_BITS-1:0]   color;
    logic                    in_accept;
    logic                    advance;
    logic                    fire;
    logic [ROW_BITS-1:0]     cur_row;
    logic [ROW_BITS-1:0]     bit_mask;
    logic                    fresh;
    logic                    mem_we;
    logic [ROW_IDX_BITS-1:0] mem_waddr;
    logic [ROW_BITS-1:0]     mem_wdata;

    // colour value is red + green<<8 + blue<<16, kept to the index width
    assign color = COLOR_BITS'({s_pixel.blue, s_pixel.green, s_pixel.red});

    // output register frees when empty or taken this cycle
    assign advance   = !m_valid_reg || m_ready;
    assign fire      = s1_valid_reg && advance;
    assign s_ready   = !clr_active_reg && (!s1_valid_reg || advance);
    assign in_accept = s_valid && s_ready;

    // forward the latest write when it hit the same row
    assign cur_row  = (wr_valid_reg && (wr_row_reg == s1_row_reg)) ? wr_data_reg
                                                                    : rd_data_reg;
    assign bit_mask = ROW_BITS'(1) << s1_sel_reg;
    assign fresh    = (cur_row & bit_mask) == '0;

    // count saturates at the bitmap size, which it never passes anyway
    assign count_next = (fresh && (count_reg < MAP_ENTRIES)) ? count_reg + 1'b1
                                                             : count_reg;

    // single write port shared by the clearing pass and the pixel updates
    always_comb begin
        if (clr_active_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_row_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = fire && fresh;
            mem_waddr = s1_row_reg;
            mem_wdata = cur_row | bit_mask;
        end
    end

    // memory: read data registered, read sees the value before a same-cycle write
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept) begin
            rd_data_reg <= map_mem[color[COLOR_BITS-1:SEL_BITS]];
        end
    end

    // clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_row_reg    <= '0;
        end else if (clr_active_reg) begin
            clr_row_reg <= clr_row_reg + 1'b1;
            if (clr_row_reg == ROW_IDX_BITS'(ROWS - 1)) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // read stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_row_reg <= color[COLOR_BITS-1:SEL_BITS];
            s1_sel_reg <= color[SEL_BITS-1:0];
        end
    end

    // forwarding register tracks the last pixel write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_valid_reg <= 1'b0;
        end else if (fire && fresh) begin
            wr_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && fresh) begin
            wr_row_reg  <= s1_row_reg;
            wr_data_reg <= cur_row | bit_mask;
        end
    end

    // running count and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_result_reg.is_new         <= fresh;
            m_result_reg.distinct_count <= COUNT_WIDTH'(count_next);
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

/* bench/colour_count_checker.sv */
`timescale 1ns / 1ps

module colour_count_checker
    import dcc_pkg::*;
#(
    parameter int COLOR_BITS = COLOR_BITS_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_ready,
    input  pixel_t  s_pixel,
    input  logic    m_valid,
    input  logic    m_ready,
    input  result_t m_result,
    output int      mismatches,
    output int      outstanding
);

    localparam longint unsigned MAP_SIZE = 64'd1 << COLOR_BITS;

    // sparse copy of the presence bitmap, keyed by truncated colour index
    bit                     colour_seen [int unsigned];
    logic [COUNT_WIDTH-1:0] colour_total;
    result_t                expected_results [$];

    function automatic result_t count_colour(pixel_t px);
        logic [23:0] full;
        int unsigned idx;
        result_t     res;
        full = {px.blue, px.green, px.red};
        idx  = 32'(full) & 32'(MAP_SIZE - 1);
        res.is_new = !colour_seen.exists(idx);
        if (res.is_new) begin
            colour_seen[idx] = 1'b1;
            if (colour_total < MAP_SIZE) begin
                colour_total++;
            end
        end
        res.distinct_count = colour_total;
        return res;
    endfunction

    task automatic note_mismatch(string what, longint unsigned want, longint unsigned got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            colour_seen.delete();
            colour_total = '0;
            expected_results.delete();
            mismatches   = 0;
        end else begin
            // queue first so a same-edge result still meets the oldest expectation
            if (s_valid && s_ready) begin
                expected_results.push_back(count_colour(s_pixel));
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result beat, is_new %0b count %0d",
                                 $realtime, m_result.is_new, m_result.distinct_count);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (m_result.is_new !== want.is_new) begin
                        note_mismatch("is_new", want.is_new, m_result.is_new);
                    end else if (m_result.distinct_count !== want.distinct_count) begin
                        note_mismatch("distinct_count", want.distinct_count,
                                      m_result.distinct_count);
                    end
                end
            end
        end
        outstanding = expected_results.size();
    end

endmodule

/* bench/distinct_color_counter_unit_test.sv */
`timescale 1ns / 1ps

module distinct_color_counter_unit_test;
    import dcc_pkg::*;

    // default index width, so the full 24-bit colour space is exercised
    localparam int COLOR_BITS   = COLOR_BITS_DEF;
    localparam int RANDOM_ITEMS = 1100;

    logic    aclk;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    pixel_t  s_pixel;
    logic    m_valid;
    logic    m_ready;
    result_t m_result;

    int mismatches;
    int outstanding;

    // colours used lately, so that repeats and same-row neighbours are common
    logic [23:0] recent_colours [$];

    distinct_color_counter_unit #(
        .COLOR_BITS (COLOR_BITS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_pixel  (s_pixel),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    // watches both channels, predicts every result and compares it
    colour_count_checker #(
        .COLOR_BITS (COLOR_BITS)
    ) count_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel     (s_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #2 aclk = ~aclk;

    // colour value is {blue, green, red}; the beat carries the bytes by name
    function automatic pixel_t pixel_of(logic [23:0] colour);
        pixel_t px;
        px.red   = colour[7:0];
        px.green = colour[15:8];
        px.blue  = colour[23:16];
        return px;
    endfunction

    // one pixel beat: optional idle gap, then hold valid until accepted.
    // entered and left on a falling edge, so a zero gap keeps valid high
    task automatic send_pixel(input logic [23:0] colour, input int unsigned gap);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= pixel_of(colour);
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        recent_colours.push_back(colour);
        if (recent_colours.size() > 32) begin
            void'(recent_colours.pop_front());
        end
    endtask

    // hold off new beats until every accepted pixel has had its result
    task automatic drain_results;
        while (outstanding != 0) @(negedge aclk);
    endtask

    // result side: random stall per beat, with stretches of constant ready
    initial begin
        int unsigned stall;
        bit          calm;
        int          beats;
        m_ready = 1'b0;
        calm    = 1'b0;
        beats   = 0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (beats % 40 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            stall = calm ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
            beats++;
        end
    end

    // stimulus and verdict
    initial begin
        logic [23:0] directed_colours [] = '{
            24'h000000, 24'h000000,             // black, then at once again
            24'hFFFFFF,                         // white
            24'h0000FF, 24'h00FF00, 24'hFF0000, // each byte alone at its top
            24'hFFFFFF,                         // repeat after other colours
            24'h000001, 24'h000002, 24'h000001, // same row, repeat still in flight
            24'h00003F, 24'h000040, 24'h000040, // across a row boundary
            24'hAA55AA, 24'h55AA55,             // alternating bit patterns
            24'h800000, 24'h000080,             // single high bit in blue, in red
            24'h070707, 24'h070707, 24'h070707  // one colour three times running
        };
        logic [23:0] colour;
        logic [23:0] base;
        int unsigned pick;
        int unsigned gap;
        bit          calm;

        aclk    = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_pixel = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed beats go back to back to hit the forwarding path
        foreach (directed_colours[i]) begin
            send_pixel(directed_colours[i], 0);
        end
        s_valid <= 1'b0;
        drain_results();

        calm = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            // pause halfway until the pipeline is empty
            if (n == RANDOM_ITEMS / 2) begin
                s_valid <= 1'b0;
                drain_results();
            end
            pick = $urandom_range(0, 99);
            base = recent_colours[$urandom_range(0, recent_colours.size() - 1)];
            if (pick < 40) begin
                // repeat of a recent colour
                colour = base;
            end else if (pick < 70) begin
                // neighbour in the same memory row as a recent colour
                colour = {base[23:SEL_BITS], 6'($urandom_range(0, ROW_BITS - 1))};
            end else if (pick < 80) begin
                // same low bytes, other blue
                colour = {8'($urandom_range(0, 255)), base[15:0]};
            end else begin
                colour = 24'($urandom);
            end
            gap = calm ? 0 : $urandom_range(0, 15);
            send_pixel(colour, gap);
        end
        s_valid <= 1'b0;

        // let the last results through, then watch for stray beats
        drain_results();
        repeat (8) @(negedge aclk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog: covers the clearing pass plus every item at its slowest, several times over
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
